/* sv/cma_eq_pkg.sv */
// cma_eq_pkg: fixed widths, constants and helper functions for the cma blind equalizer
// no dependencies; used by cma_blind_equalizer through scoped names
`timescale 1ns / 1ps

package cma_eq_pkg;

    // coefficient and step formats
    localparam int TAP_W     = 20;      // Q5.14 signed
    localparam int TAP_ONE   = 16384;   // 1.0 in Q5.14
    localparam int TAP_MAX   = 524287;
    localparam int TAP_MIN   = -524288;
    localparam int MU_W      = 16;      // Q0.16 unsigned
    localparam int FRAC_BITS = 12;      // sample fraction bits
    localparam int ONE_Q12   = 4096;

    // configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_MU_START = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MU_DEC   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MU_FLOOR = 2'd2;

    // reset values of the registers
    localparam logic [MU_W-1:0] MU_START_RST = 16'd26214;
    localparam logic [MU_W-1:0] MU_DEC_RST   = 16'd0;
    localparam logic [MU_W-1:0] MU_FLOOR_RST = 16'd1;

    typedef logic signed [TAP_W-1:0] tap_t;
    typedef logic [MU_W-1:0]         mu_t;

    // elaboration-time width helpers
    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int imin(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

endpackage

/* sv/cma_blind_equalizer.sv */
// cma_blind_equalizer: constant-modulus adaptive fir equalizer, top level
// depends on cma_eq_pkg (widths, constants, register indexes)
`timescale 1ns / 1ps

// Usage
// The s_ channel carries one received sample per request (tdata bits
// [SAMPLE_BITS-1:0], signed Q3.12); the m_ channel returns one equalized,
// saturated sample per request in the same format. Step-size registers are
// written through cfg_wr_en / cfg_addr / cfg_wdata; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Each sample adapts each tap in turn with the constant-modulus rule using the
// previous output, then applies that updated tap in the filter. All products
// go through one shared signed multiplier followed by a round/clamp stage,
// under a small sequencer: the error term, then per tap three update products,
// the tap write and one filter product, and a final round and saturate step.
// A new sample is taken only in the idle state, once the last result is done.
// The result sits in an output register, so the next sample is accepted while
// it waits; if the receiver is still stalled when the next result is done,
// the sequencer holds in its final step until the output register frees.
// Reset (aresetn low at a clock edge) sets all taps and the previous output
// to 1.0, clears the sample history and restores the register defaults; the
// first sample after reset loads the step size as max(mu_start, mu_floor).

module cma_blind_equalizer #(
    parameter int TAP_COUNT   = 3,
    parameter int SAMPLE_BITS = 16,
    localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // sample input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [DATA_W-1:0]               s_tdata,   // rx_sample
    // equalized output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [DATA_W-1:0]               m_tdata,   // eq_sample
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [cma_eq_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [cma_eq_pkg::MU_W-1:0]     cfg_wdata
);

    // datapath widths
    localparam int SB  = SAMPLE_BITS;
    localparam int TW0 = cma_eq_pkg::TAP_W;
    localparam int EW  = cma_eq_pkg::imax(SB, 14);
    localparam int PW  = cma_eq_pkg::imin(EW + SB - 12, 33);
    localparam int GW  = cma_eq_pkg::imin(cma_eq_pkg::imax(2 * EW - 11, 14), 33);
    localparam int TW  = cma_eq_pkg::imin(PW + GW - 10, 42);
    localparam int DW  = cma_eq_pkg::imin(TW + 1, 42);
    localparam int MA  = cma_eq_pkg::imax(cma_eq_pkg::imax(EW, PW),
                                          cma_eq_pkg::imax(TW, TW0));
    localparam int MB  = cma_eq_pkg::imax(cma_eq_pkg::imax(EW, SB),
                                          cma_eq_pkg::imax(GW, cma_eq_pkg::MU_W + 1));
    localparam int PRW = MA + MB;
    localparam int RW  = cma_eq_pkg::imax(PRW + 1, 43);
    localparam int AW  = TW0 + SB + $clog2(TAP_COUNT) + 1;
    localparam int AW1 = AW + 1;
    localparam int IW  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

    // rounding and clamp constants
    localparam logic signed [RW-1:0] HALF10  = RW'(64'sd512);
    localparam logic signed [RW-1:0] HALF12  = RW'(64'sd2048);
    localparam logic signed [RW-1:0] HALF16  = RW'(64'sd32768);
    localparam logic signed [RW-1:0] ONE_Q12 = RW'(cma_eq_pkg::ONE_Q12);
    localparam logic signed [RW-1:0] LIM31   = RW'(64'sh0000_0000_8000_0000);
    localparam logic signed [RW-1:0] LIM40   = RW'(64'sh0000_0100_0000_0000);
    localparam logic signed [RW-1:0] WMAX    = RW'(cma_eq_pkg::TAP_MAX);
    localparam logic signed [RW-1:0] WMIN    = RW'(cma_eq_pkg::TAP_MIN);
    localparam logic signed [AW1-1:0] HALF14 = AW1'(64'sd8192);
    localparam logic signed [AW1-1:0] YMAX   = AW1'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [AW1-1:0] YMIN   = -YMAX - AW1'(64'sd1);
    localparam logic [IW-1:0]         IDX_LAST = IW'(TAP_COUNT - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GMUL  = 4'd1;
    localparam logic [3:0] S_GPOST = 4'd2;
    localparam logic [3:0] S_PMUL  = 4'd3;
    localparam logic [3:0] S_PPOST = 4'd4;
    localparam logic [3:0] S_TMUL  = 4'd5;
    localparam logic [3:0] S_TPOST = 4'd6;
    localparam logic [3:0] S_DMUL  = 4'd7;
    localparam logic [3:0] S_DPOST = 4'd8;
    localparam logic [3:0] S_WUPD  = 4'd9;
    localparam logic [3:0] S_MMUL  = 4'd10;
    localparam logic [3:0] S_MPOST = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    // control state
    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg;
    logic          running_reg;
    logic          m_tvalid_reg;

    // configuration registers
    cma_eq_pkg::mu_t mu_start_reg, mu_dec_reg, mu_floor_reg;
    cma_eq_pkg::mu_t step_reg;

    // filter state
    cma_eq_pkg::tap_t      tap_reg  [TAP_COUNT];
    logic signed [SB-1:0]  hist_reg [TAP_COUNT];
    logic signed [EW-1:0]  e_reg;

    // per-sample working registers
    logic signed [SB-1:0]  x0_reg;
    logic signed [GW-1:0]  g_reg;
    logic signed [PW-1:0]  p_reg;
    logic signed [TW-1:0]  t_reg;
    logic signed [DW-1:0]  d_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [PRW-1:0] prod_reg;
    logic signed [SB-1:0]  m_sample_reg;

    // combinational nets
    logic                  accept;
    logic                  fin_go;
    logic [IW-1:0]         rd_idx;
    logic signed [SB-1:0]  smp_rd;
    cma_eq_pkg::tap_t      tap_rd;
    logic signed [MA-1:0]  mul_a;
    logic signed [MB-1:0]  mul_b;
    logic signed [RW-1:0]  prod_ext, rnd_val, post_val, lim, clamped;
    logic signed [RW-1:0]  w_diff;
    cma_eq_pkg::tap_t      w_new;
    logic signed [AW1-1:0] acc_rnd;
    logic signed [SB-1:0]  y_val;
    cma_eq_pkg::mu_t       step_dec, step_new, step_first;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'($unsigned(m_sample_reg));
    assign fin_go   = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);

    // history read port: the filter step needs the sample one place newer
    always_comb begin
        rd_idx = idx_reg;
        if (state_reg == S_MMUL) begin
            rd_idx = idx_reg - IW'(1);
        end
        smp_rd = hist_reg[rd_idx];
        if (state_reg == S_MMUL && idx_reg == '0) begin
            smp_rd = x0_reg;
        end
        tap_rd = tap_reg[idx_reg];
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_GMUL: begin
                mul_a = MA'(e_reg);
                mul_b = MB'(e_reg);
            end
            S_PMUL: begin
                mul_a = MA'(e_reg);
                mul_b = MB'(smp_rd);
            end
            S_TMUL: begin
                mul_a = MA'(p_reg);
                mul_b = MB'(g_reg);
            end
            S_DMUL: begin
                mul_a = MA'(t_reg);
                mul_b = MB'(signed'({1'b0, step_reg}));
            end
            S_MMUL: begin
                mul_a = MA'(tap_rd);
                mul_b = MB'(smp_rd);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared multiplier, product registered
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // round, offset and clamp stage after the multiplier
    always_comb begin
        prod_ext = RW'(prod_reg);
        case (state_reg)
            S_TPOST: rnd_val = (prod_ext + HALF10) >>> 10;
            S_DPOST: rnd_val = (prod_ext + HALF16) >>> 16;
            default: rnd_val = (prod_ext + HALF12) >>> cma_eq_pkg::FRAC_BITS;
        endcase
        post_val = (state_reg == S_GPOST) ? (rnd_val - ONE_Q12) : rnd_val;
        lim = (state_reg == S_TPOST || state_reg == S_DPOST) ? LIM40 : LIM31;
        if (post_val > lim) begin
            clamped = lim;
        end else if (post_val < -lim) begin
            clamped = -lim;
        end else begin
            clamped = post_val;
        end
    end

    // tap update with saturation
    always_comb begin
        w_diff = RW'(tap_rd) - RW'(d_reg);
        if (w_diff > WMAX) begin
            w_new = cma_eq_pkg::tap_t'(cma_eq_pkg::TAP_MAX);
        end else if (w_diff < WMIN) begin
            w_new = cma_eq_pkg::tap_t'(cma_eq_pkg::TAP_MIN);
        end else begin
            w_new = TW0'(w_diff);
        end
    end

    // output rounding and saturation
    always_comb begin
        acc_rnd = (AW1'(acc_reg) + HALF14) >>> 14;
        if (acc_rnd > YMAX) begin
            y_val = SB'(YMAX);
        end else if (acc_rnd < YMIN) begin
            y_val = SB'(YMIN);
        end else begin
            y_val = SB'(acc_rnd);
        end
    end

    // step size: first load and per-sample decay with floor
    always_comb begin
        step_first = (mu_start_reg > mu_floor_reg) ? mu_start_reg : mu_floor_reg;
        step_dec   = (step_reg > mu_dec_reg) ? (step_reg - mu_dec_reg) : '0;
        step_new   = (step_dec < mu_floor_reg) ? mu_floor_reg : step_dec;
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_GMUL;
            S_GMUL:  state_next = S_GPOST;
            S_GPOST: state_next = S_PMUL;
            S_PMUL:  state_next = S_PPOST;
            S_PPOST: state_next = S_TMUL;
            S_TMUL:  state_next = S_TPOST;
            S_TPOST: state_next = S_DMUL;
            S_DMUL:  state_next = S_DPOST;
            S_DPOST: state_next = S_WUPD;
            S_WUPD:  state_next = S_MMUL;
            S_MMUL:  state_next = S_MPOST;
            S_MPOST: state_next = (idx_reg == IDX_LAST) ? S_FIN : S_PMUL;
            S_FIN:   if (fin_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            running_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                idx_reg     <= '0;
                running_reg <= 1'b1;
            end else if (state_reg == S_MPOST && idx_reg != IDX_LAST) begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (fin_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // configuration registers and step size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_start_reg <= cma_eq_pkg::MU_START_RST;
            mu_dec_reg   <= cma_eq_pkg::MU_DEC_RST;
            mu_floor_reg <= cma_eq_pkg::MU_FLOOR_RST;
            step_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    cma_eq_pkg::REG_MU_START: mu_start_reg <= cfg_wdata;
                    cma_eq_pkg::REG_MU_DEC:   mu_dec_reg   <= cfg_wdata;
                    cma_eq_pkg::REG_MU_FLOOR: mu_floor_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept && !running_reg) begin
                step_reg <= step_first;
            end else if (fin_go) begin
                step_reg <= step_new;
            end
        end
    end

    // filter state: taps, history, previous output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TAP_COUNT; k++) begin
                tap_reg[k]  <= cma_eq_pkg::tap_t'(cma_eq_pkg::TAP_ONE);
                hist_reg[k] <= '0;
            end
            e_reg <= EW'(cma_eq_pkg::ONE_Q12);
        end else begin
            if (state_reg == S_WUPD) begin
                tap_reg[idx_reg] <= w_new;
            end
            if (fin_go) begin
                hist_reg[0] <= x0_reg;
                for (int k = 1; k < TAP_COUNT; k++) begin
                    hist_reg[k] <= hist_reg[k-1];
                end
                e_reg <= EW'(y_val);
            end
        end
    end

    // per-sample working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            x0_reg  <= s_tdata[SB-1:0];
            acc_reg <= '0;
        end
        case (state_reg)
            S_GPOST: g_reg   <= GW'(clamped);
            S_PPOST: p_reg   <= PW'(clamped);
            S_TPOST: t_reg   <= TW'(clamped);
            S_DPOST: d_reg   <= DW'(clamped);
            S_MPOST: acc_reg <= acc_reg + AW'(prod_reg);
            default: ;
        endcase
        if (fin_go) begin
            m_sample_reg <= y_val;
        end
    end

    // a result appears only from the final step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_FIN)
        else $error("output valid raised outside the final step");

    // tap index never runs past the last tap
    assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IDX_LAST)
        else $error("tap index out of range");

    // step size after decay respects the floor
    assert property (@(posedge aclk) disable iff (!aresetn)
        fin_go |=> step_reg >= $past(mu_floor_reg))
        else $error("step size below floor");

    // the stored previous output matches the sample sent out
    assert property (@(posedge aclk) disable iff (!aresetn)
        fin_go |=> e_reg == EW'(m_sample_reg))
        else $error("previous output differs from delivered sample");

endmodule
